/* hdl/sbm_pkg.sv */
`timescale 1ns / 1ps

package sbm_pkg;

  localparam int SEARCH_RADIUS = 8;
  localparam int WINDOW_WIDTH  = 5;
  localparam int MAX_ROW_WIDTH = 4096;

  localparam int LAG         = SEARCH_RADIUS + WINDOW_WIDTH - 1;
  localparam int NUM_SHIFTS  = 2 * SEARCH_RADIUS + 1;
  localparam int SPAN        = WINDOW_WIDTH + 2 * SEARCH_RADIUS;
  localparam int LEFT_TAPS   = LAG;
  localparam int RIGHT_TAPS  = SPAN - 1;
  localparam int FLUSH_STEPS = WINDOW_WIDTH - 1;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 12;
  localparam int CNT_W      = 13;
  localparam int POS_W      = CNT_W + 1;
  localparam int ROWW_W     = 13;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CODE_W     = 8;
  localparam int IDX_W      = $clog2(NUM_SHIFTS);
  localparam int DIFF_W     = PIX_W + 2;
  localparam int MAG_W      = PIX_W + 1;
  localparam int SQ_W       = 2 * MAG_W - 1;
  localparam int COST_W     = $clog2(WINDOW_WIDTH * (1 << (2 * PIX_W)) + 1);
  localparam int FLUSH_W    = $clog2(FLUSH_STEPS + 1);

  localparam int LEVEL_MID  = 128;
  localparam int LEVEL_FULL = 256;
  localparam int CODE_BASE  = 256 - 64;
  localparam int CODE_SHIFT = 3;
  localparam int CODE_MIN   = CODE_BASE - (NUM_SHIFTS - 1) * (1 << CODE_SHIFT);

  localparam logic [MODE_W-1:0] MODE_SSD_LEVEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX_SUM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SSD_GRAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd2;

  localparam logic [MODE_W-1:0] RESET_MODE  = MODE_SSD_LEVEL;
  localparam logic [THR_W-1:0]  RESET_THR   = 8'd8;
  localparam logic [ROWW_W-1:0] RESET_WIDTH = 13'd640;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t [WINDOW_WIDTH-1:0] left;
    pixel_t [SPAN-1:0]         right;
  } window_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  column;
    logic              last;
    logic              textured;
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  idx;
  } score_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  column;
    logic              last;
  } result_t;

  function automatic logic [CODE_W-1:0] shift_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] step;
    step = CODE_W'({idx, {CODE_SHIFT{1'b0}}});
    return CODE_W'(CODE_BASE) - step;
  endfunction

endpackage

/* hdl/sbm_in_if.sv */
`timescale 1ns / 1ps

interface sbm_in_if import sbm_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t left_pixel;
  pixel_t right_pixel;

  modport source (output valid, output left_pixel, output right_pixel, input ready);
  modport sink (input valid, input left_pixel, input right_pixel, output ready);
endinterface

/* hdl/sbm_out_if.sv */
`timescale 1ns / 1ps

interface sbm_out_if import sbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] disparity_code;
  logic [COL_W-1:0]  column;
  logic              last_in_row;

  modport source (output valid, output disparity_code, output column, output last_in_row,
                  input ready);
  modport sink (input valid, input disparity_code, input column, input last_in_row,
                output ready);
endinterface

/* hdl/stereo_block_match_disparity.sv */
// A result passes the front's metadata register and the 17-cell scoring chain, one cell
// per shift with its registered squares, before it reaches the output register.
// One pixel pair per cycle while the output buffer is not full; the last pixel of a row
// is followed by WINDOW_WIDTH - 1 zero pixels, taking no item, that close the row's windows.
// Reset (synchronous, active low) restores register defaults and clears the delay lines,
// the column counter and all valid flags.
`timescale 1ns / 1ps

module stereo_block_match_disparity import sbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sbm_in_if.sink                in_ch,
  sbm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0] match_mode_r;
  logic [THR_W-1:0]  texture_threshold_r;
  logic [ROWW_W-1:0] row_width_r;
  logic              adv;
  logic              full;
  logic              flushing;
  logic              accept;
  logic              maximize;
  window_t           chain_win [NUM_SHIFTS];
  score_t            chain_score [NUM_SHIFTS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r        <= RESET_MODE;
      texture_threshold_r <= RESET_THR;
      row_width_r         <= RESET_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_MODE:  match_mode_r        <= cfg_data[MODE_W-1:0];
        CFG_TEXTURE_THR: texture_threshold_r <= cfg_data[THR_W-1:0];
        CFG_ROW_WIDTH:   row_width_r         <= cfg_data[ROWW_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !full;
  assign in_ch.ready = !full && !flushing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign maximize    = (match_mode_r == MODE_MAX_SUM);

  sbm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .accept            (accept),
    .left_pixel        (in_ch.left_pixel),
    .right_pixel       (in_ch.right_pixel),
    .match_mode        (match_mode_r),
    .texture_threshold (texture_threshold_r),
    .row_width         (row_width_r),
    .flushing          (flushing),
    .win               (chain_win[0]),
    .meta_r            (chain_score[0])
  );

  for (genvar s = 0; s < NUM_SHIFTS; s++) begin : g_chain
    if (s < NUM_SHIFTS - 1) begin : g_mid
      sbm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .maximize  (maximize),
        .shift_idx (IDX_W'(s)),
        .win_in    (chain_win[s]),
        .score_in  (chain_score[s]),
        .win_out   (chain_win[s+1]),
        .score_out (chain_score[s+1])
      );
    end else begin : g_end
      sbm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .maximize  (maximize),
        .shift_idx (IDX_W'(s)),
        .win_in    (chain_win[s]),
        .score_in  (chain_score[s]),
        .win_out   (),
        .score_out (chain_score[s+1])
      );
    end
  end

  sbm_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (adv && chain_score[NUM_SHIFTS].valid),
    .tail   (chain_score[NUM_SHIFTS]),
    .full   (full),
    .out_ch (out_ch)
  );

endmodule

/* hdl/sbm_front.sv */
`timescale 1ns / 1ps

module sbm_front import sbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              accept,
  input  pixel_t            left_pixel,
  input  pixel_t            right_pixel,
  input  logic [MODE_W-1:0] match_mode,
  input  logic [THR_W-1:0]  texture_threshold,
  input  logic [ROWW_W-1:0] row_width,
  output logic              flushing,
  output window_t           win,
  output score_t            meta_r
);

  localparam logic signed [POS_W-1:0] POS_LAG = POS_W'(LAG);
  localparam logic signed [POS_W-1:0] POS_LO  = POS_W'(SEARCH_RADIUS);
  localparam logic signed [POS_W-1:0] POS_OFF = POS_W'(SEARCH_RADIUS + 1);

  pixel_t                    left_r [LEFT_TAPS];
  pixel_t                    right_r [RIGHT_TAPS];
  logic [CNT_W-1:0]          col_r;
  logic [CNT_W-1:0]          col_nxt;
  logic [FLUSH_W-1:0]        flush_r;
  logic [FLUSH_W-1:0]        flush_nxt;
  logic                      step;
  pixel_t                    new_left;
  pixel_t                    new_right;
  logic [ROWW_W-1:0]         width;
  logic                      last;
  logic signed [POS_W-1:0]   x;
  logic signed [POS_W-1:0]   hi;
  logic                      emit;
  logic                      textured;
  pixel_t                    l0;
  pixel_t                    l1;
  pixel_t                    grad;
  score_t                    meta_nxt;

  always_comb begin
    flushing  = (flush_r != '0);
    step      = accept || (flushing && adv);
    new_left  = accept ? left_pixel : '0;
    new_right = accept ? right_pixel : '0;

    if (row_width == '0) begin
      width = ROWW_W'(1);
    end else if (row_width > ROWW_W'(MAX_ROW_WIDTH)) begin
      width = ROWW_W'(MAX_ROW_WIDTH);
    end else begin
      width = row_width;
    end

    last = accept && (col_r >= (width - ROWW_W'(1)));
    x    = $signed({1'b0, col_r}) - POS_LAG;
    hi   = $signed({1'b0, width}) - POS_OFF;
    emit = step && (x >= POS_LO) && (x <= hi);

    l0   = left_r[LAG-1];
    l1   = left_r[LAG-2];
    grad = (l0 >= l1) ? (l0 - l1) : (l1 - l0);
    if (match_mode == MODE_SSD_GRAD) begin
      textured = grad > texture_threshold;
    end else begin
      textured = (({2'b00, l0} + {2'b00, texture_threshold}) < DIFF_W'(LEVEL_MID)) ||
                 ({2'b00, l0} > (DIFF_W'(LEVEL_MID) + {2'b00, texture_threshold}));
    end
  end

  always_comb begin
    for (int j = 0; j < WINDOW_WIDTH; j++) begin
      win.left[j] = left_r[LAG-1-j];
    end
    for (int k = 0; k < SPAN - 1; k++) begin
      win.right[k] = right_r[SPAN-2-k];
    end
    win.right[SPAN-1] = new_right;
  end

  always_comb begin
    meta_nxt          = '0;
    meta_nxt.valid    = emit;
    meta_nxt.column   = x[COL_W-1:0];
    meta_nxt.last     = (x == hi);
    meta_nxt.textured = textured;
  end

  always_comb begin
    col_nxt   = col_r;
    flush_nxt = flush_r;
    if (accept) begin
      col_nxt = col_r + CNT_W'(1);
      if (last) begin
        flush_nxt = FLUSH_W'(FLUSH_STEPS);
      end
    end else if (flushing && adv) begin
      flush_nxt = flush_r - FLUSH_W'(1);
      col_nxt   = (flush_r == FLUSH_W'(1)) ? '0 : (col_r + CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      flush_r <= '0;
      meta_r  <= '0;
      for (int i = 0; i < LEFT_TAPS; i++) begin
        left_r[i] <= '0;
      end
      for (int i = 0; i < RIGHT_TAPS; i++) begin
        right_r[i] <= '0;
      end
    end else begin
      col_r   <= col_nxt;
      flush_r <= flush_nxt;
      if (adv) begin
        meta_r <= meta_nxt;
      end
      if (step) begin
        left_r[0]  <= new_left;
        right_r[0] <= new_right;
        for (int i = 1; i < LEFT_TAPS; i++) begin
          left_r[i] <= left_r[i-1];
        end
        for (int i = 1; i < RIGHT_TAPS; i++) begin
          right_r[i] <= right_r[i-1];
        end
      end
    end
  end

endmodule

/* hdl/sbm_cell.sv */
`timescale 1ns / 1ps

module sbm_cell import sbm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             maximize,
  input  logic [IDX_W-1:0] shift_idx,
  input  window_t          win_in,
  input  score_t           score_in,
  output window_t          win_out,
  output score_t           score_out
);

  logic [DIFF_W-1:0]  term [WINDOW_WIDTH];
  logic [MAG_W-1:0]   mag [WINDOW_WIDTH];
  logic [2*MAG_W-1:0] mag_ext [WINDOW_WIDTH];
  logic [SQ_W-1:0]    sq_nxt [WINDOW_WIDTH];
  logic [SQ_W-1:0]    sq_r [WINDOW_WIDTH];
  logic [COST_W-1:0]  sum;
  logic               better;
  logic               take;
  score_t             score_nxt;
  score_t             score_r;
  window_t            win_nxt;
  window_t            win_r;

  always_comb begin
    for (int j = 0; j < WINDOW_WIDTH; j++) begin
      if (maximize) begin
        term[j] = {2'b00, win_in.left[j]} + {2'b00, win_in.right[j]} - DIFF_W'(LEVEL_FULL);
      end else begin
        term[j] = {2'b00, win_in.left[j]} - {2'b00, win_in.right[j]};
      end
      mag[j]     = term[j][DIFF_W-1] ? MAG_W'(~term[j] + DIFF_W'(1)) : MAG_W'(term[j]);
      mag_ext[j] = {{MAG_W{1'b0}}, mag[j]};
      sq_nxt[j]  = SQ_W'(mag_ext[j] * mag_ext[j]);
    end
  end

  always_comb begin
    win_nxt.left = win_in.left;
    for (int k = 0; k < SPAN - 1; k++) begin
      win_nxt.right[k] = win_in.right[k+1];
    end
    win_nxt.right[SPAN-1] = '0;
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < WINDOW_WIDTH; j++) begin
      sum = sum + COST_W'(sq_r[j]);
    end
    better    = maximize ? (sum > score_in.cost) : (sum < score_in.cost);
    take      = (shift_idx == '0) || better;
    score_nxt = score_in;
    if (take) begin
      score_nxt.cost = sum;
      score_nxt.idx  = shift_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else if (adv) begin
      score_r <= score_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= win_nxt;
      for (int j = 0; j < WINDOW_WIDTH; j++) begin
        sq_r[j] <= sq_nxt[j];
      end
    end
  end

  assign win_out   = win_r;
  assign score_out = score_r;

endmodule

/* hdl/sbm_outbuf.sv */
`timescale 1ns / 1ps

module sbm_outbuf import sbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  score_t     tail,
  output logic       full,
  sbm_out_if.source  out_ch
);

  result_t res_new;
  result_t out_r;
  result_t out_nxt;
  result_t sk_r;
  result_t sk_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    sk_valid_r;
  logic    sk_valid_nxt;
  logic    pop;

  always_comb begin
    res_new.code   = tail.textured ? shift_code(tail.idx) : '0;
    res_new.column = tail.column;
    res_new.last   = tail.last;
  end

  always_comb begin
    pop           = out_valid_r && out_ch.ready;
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    out_nxt       = out_r;
    sk_nxt        = sk_r;
    if (sk_valid_r) begin
      if (pop) begin
        out_nxt      = sk_r;
        sk_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_nxt       = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        sk_nxt       = res_new;
        sk_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign full                  = sk_valid_r;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.disparity_code = out_r.code;
  assign out_ch.column         = out_r.column;
  assign out_ch.last_in_row    = out_r.last;

endmodule

/* hdl/sbm_checker.sv */
`timescale 1ns / 1ps

module sbm_checker import sbm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] disparity_code,
  input logic [COL_W-1:0]  column,
  input logic              last_in_row
);

  logic seen_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_in_r <= 1'b1;
    end
  end

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(disparity_code) && $stable(column) &&
    $stable(last_in_row))
    else $error("stalled result changed");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_in_r)
    else $error("result without any accepted item");

  a_code_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (disparity_code[CODE_SHIFT-1:0] == '0) &&
    (column >= COL_W'(SEARCH_RADIUS)) &&
    ((disparity_code == '0) ||
     ((disparity_code >= CODE_W'(CODE_MIN)) && (disparity_code <= CODE_W'(CODE_BASE)))))
    else $error("result code or column out of range");

endmodule

bind stereo_block_match_disparity sbm_checker u_sbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .disparity_code (out_ch.disparity_code),
  .column         (out_ch.column),
  .last_in_row    (out_ch.last_in_row)
);

/* tb/sbm_disparity_check_pkg.sv */
`timescale 1ns / 1ps

package sbm_disparity_check_pkg;
  import sbm_pkg::*;

  class disparity_tracker;
    pixel_t            left_hist[LAG + 1];
    pixel_t            right_hist[LAG + SEARCH_RADIUS + 1];
    int                col_count;
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  thr;
    logic [ROWW_W-1:0] width;
    result_t           pending[$];
    int                taken;
    int                checked;
    int                errors;

    function new();
      foreach (left_hist[i]) left_hist[i] = '0;
      foreach (right_hist[i]) right_hist[i] = '0;
      col_count = 0;
      mode = RESET_MODE;
      thr = RESET_THR;
      width = RESET_WIDTH;
      taken = 0;
      checked = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MATCH_MODE: begin
          mode = data[MODE_W-1:0];
        end
        CFG_TEXTURE_THR: begin
          thr = data[THR_W-1:0];
        end
        CFG_ROW_WIDTH: begin
          width = data[ROWW_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int left_at(int newest, int c);
      if (c < 0 || c > newest || newest - c > LAG) return 0;
      return int'(left_hist[newest - c]);
    endfunction

    function int right_at(int newest, int c);
      if (c < 0 || c > newest || newest - c > LAG + SEARCH_RADIUS) return 0;
      return int'(right_hist[newest - c]);
    endfunction

    function result_t score_column(int x, int n);
      result_t res;
      int      t;
      int      l0;
      int      l1;
      int      grad;
      int      v;
      int      cost;
      int      best;
      int      best_idx;
      int      lp;
      int      rp;
      bit      textured;
      bit      maximize;
      t = int'(thr);
      l0 = left_at(n, x);
      l1 = left_at(n, x + 1);
      maximize = (mode == MODE_MAX_SUM);
      if (mode == MODE_SSD_GRAD) begin
        grad = l0 - l1;
        if (grad < 0) grad = -grad;
        textured = grad > t;
      end else begin
        textured = (l0 < LEVEL_MID - t) || (l0 > LEVEL_MID + t);
      end
      res.code = '0;
      res.column = COL_W'(x);
      res.last = 1'b0;
      if (!textured) return res;
      best = 0;
      best_idx = 0;
      for (int s = 0; s < NUM_SHIFTS; s++) begin
        cost = 0;
        for (int j = 0; j < WINDOW_WIDTH; j++) begin
          lp = left_at(n, x + j);
          rp = right_at(n, x + j + s - SEARCH_RADIUS);
          v = maximize ? (lp - LEVEL_MID) + (rp - LEVEL_MID) : lp - rp;
          cost += v * v;
        end
        if (s == 0 || (maximize ? cost > best : cost < best)) begin
          best = cost;
          best_idx = s;
        end
      end
      res.code = CODE_W'(CODE_BASE - (best_idx << CODE_SHIFT));
      return res;
    endfunction

    function void take_pixel(pixel_t l, pixel_t r);
      int      w;
      int      n;
      int      hi;
      int      x;
      bit      row_end;
      result_t batch[$];
      for (int i = LAG; i > 0; i--) left_hist[i] = left_hist[i-1];
      for (int i = LAG + SEARCH_RADIUS; i > 0; i--) right_hist[i] = right_hist[i-1];
      left_hist[0] = l;
      right_hist[0] = r;
      w = int'(width);
      if (w < 1) w = 1;
      if (w > MAX_ROW_WIDTH) w = MAX_ROW_WIDTH;
      n = col_count;
      row_end = n >= w - 1;
      hi = w - 1 - SEARCH_RADIUS;
      x = n - LAG;
      if (x >= SEARCH_RADIUS && x <= hi) batch.push_back(score_column(x, n));
      if (row_end) begin
        for (x = n - LAG + 1; x <= hi; x++) begin
          if (x >= SEARCH_RADIUS) batch.push_back(score_column(x, n));
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        col_count = 0;
      end else begin
        col_count = n + 1;
      end
      foreach (batch[i]) pending.push_back(batch[i]);
      taken++;
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_disparity(logic [CODE_W-1:0] code, logic [COL_W-1:0] column,
                                  logic last);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        note_failure($sformatf("unexpected result: code %0d column %0d last %0b",
                               code, column, last));
        return;
      end
      want = pending.pop_front();
      if (want.code !== code || want.column !== column || want.last !== last)
        note_failure($sformatf("expected code %0d column %0d last %0b, got %0d %0d %0b",
                               want.code, want.column, want.last, code, column, last));
    endfunction

    function void close_out();
      if (pending.size() != 0)
        note_failure($sformatf("%0d expected results never arrived", pending.size()));
    endfunction
  endclass

endpackage

/* tb/stereo_block_match_disparity_test.sv */
`timescale 1ns / 1ps

module stereo_block_match_disparity_test;
  import sbm_pkg::*;
  import sbm_disparity_check_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_ALIAS  = 2'd3;

  typedef enum int {ROW_NOISE, ROW_FLAT, ROW_SHIFTED} row_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sbm_in_if  in_ch();
  sbm_out_if out_ch();

  disparity_tracker tracker = new();

  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_request = 0;
  int     quiet_cycles = 0;
  int     phases = 0;
  pixel_t row_left[];
  pixel_t row_right[];
  pixel_t probe_left[21] = '{0, 0, 0, 0, 0, 0, 0, 0, 255, 128, 0, 255, 120, 137, 255, 1,
                             254, 0, 255, 136, 0};

  stereo_block_match_disparity u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("stereo_block_match_disparity verification failed");
    $finish;
  end

  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_disparity(out_ch.disparity_code, out_ch.column, out_ch.last_in_row);
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_pixel(input pixel_t l, input pixel_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.left_pixel <= pixel_t'($urandom);
      in_ch.right_pixel <= pixel_t'($urandom);
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_pixel <= l;
    in_ch.right_pixel <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_pixel(l, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [THR_W-1:0] thr,
                           input logic [ROWW_W-1:0] width);
    write_reg(CFG_MATCH_MODE, {(CFG_DATA_W - MODE_W)'($urandom), mode});
    write_reg(CFG_TEXTURE_THR, {(CFG_DATA_W - THR_W)'($urandom), thr});
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void build_row(input int span);
    row_style_e style;
    int         pick;
    int         shift;
    pixel_t     base;
    pick = $urandom_range(9);
    style = (pick == 0) ? ROW_NOISE : ((pick == 1) ? ROW_FLAT : ROW_SHIFTED);
    shift = $urandom_range(2 * SEARCH_RADIUS) - SEARCH_RADIUS;
    base = pixel_t'($urandom);
    row_left = new[span];
    row_right = new[span];
    for (int c = 0; c < span; c++) begin
      case (style)
        ROW_NOISE: begin
          row_left[c] = pixel_t'($urandom);
          row_right[c] = pixel_t'($urandom);
        end
        ROW_FLAT: begin
          row_left[c] = base;
          row_right[c] = base;
        end
        default: begin
          row_left[c] = ($urandom_range(3) == 0) ? pixel_t'($urandom_range(160, 96))
                                                 : pixel_t'($urandom);
        end
      endcase
    end
    if (style == ROW_SHIFTED) begin
      for (int c = 0; c < span; c++) begin
        row_right[c] = (c - shift >= 0 && c - shift < span) ? row_left[c - shift]
                                                            : pixel_t'($urandom);
        if ($urandom_range(15) == 0) row_right[c] = row_right[c] ^ pixel_t'($urandom_range(7));
      end
    end
  endfunction

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [THR_W-1:0] thr,
                           input logic [ROWW_W-1:0] width, input int items,
                           input int idle_pct, input int busy_pct, input bit hold);
    int span;
    int pos;
    configure(mode, thr, width);
    send_idle_pct = idle_pct;
    stall_pct = busy_pct;
    if (hold) hold_request++;
    span = (width == 0) ? 1 : ((width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width));
    pos = 0;
    for (int i = 0; i < items; i++) begin
      if (pos == 0) build_row(span);
      send_pixel(row_left[pos], row_right[pos]);
      pos = (pos + 1) % span;
    end
    in_ch.valid <= 1'b0;
    wait_idle();
    phases++;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_pixel = '0;
    in_ch.right_pixel = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A short row whose final pixel flushes five columns, with windows running past the end.
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    configure(MODE_SSD_LEVEL, 8'd8, 13'd21);
    for (int c = 0; c < 21; c++)
      send_pixel(probe_left[c], (c >= 3) ? probe_left[c - 3] : 8'hff);
    in_ch.valid <= 1'b0;
    wait_idle();
    phases++;

    run_phase(MODE_MAX_SUM, 8'd0, 13'd40, 40, 77, 0, 1'b0);
    run_phase(MODE_SSD_GRAD, 8'd20, 13'd33, 33, 0, 77, 1'b0);
    run_phase(MODE_ALIAS, 8'd255, 13'd32, 32, 19, 19, 1'b0);
    run_phase(MODE_SSD_GRAD, 8'd0, 13'd48, 20, 19, 19, 1'b0);
    run_phase(MODE_SSD_GRAD, 8'd0, 13'd20, 21, 0, 0, 1'b0);
    run_phase(MODE_MAX_SUM, 8'd128, 13'd0, 8, 77, 0, 1'b0);
    run_phase(MODE_SSD_LEVEL, 8'd40, 13'd16, 16, 0, 0, 1'b0);
    run_phase(MODE_SSD_LEVEL, 8'd4, 13'd32, 48, 0, 0, 1'b1);
    run_phase(MODE_MAX_SUM, 8'd200, 13'd8191, 8, 0, 0, 1'b0);
    run_phase(MODE_SSD_LEVEL, 8'd16, 13'd36, 36, 19, 19, 1'b0);

    tracker.close_out();
    $display("Checked %0d disparity results from %0d pixel pairs over %0d register settings,",
             tracker.checked, tracker.taken, phases);
    $display("spanning all match modes, threshold and row width extremes and output hold-off.");
    if (tracker.errors == 0) begin
      $display("stereo_block_match_disparity verification clean");
    end else begin
      $display("%0d mismatches in total", tracker.errors);
      $display("stereo_block_match_disparity verification failed");
    end
    $finish;
  end

endmodule
